// File: rtl/sfr_pkg.sv
// ----------------------------------------------------------------------------
// sfr_pkg
// Shared types, character codes and the X.25 CRC byte update for the SDLC
// frame receiver link.
// ----------------------------------------------------------------------------
package sfr_pkg;

  // Item opcodes on the input stream
  typedef enum logic [1:0] {
    OP_RX_CHAR     = 2'd0,
    OP_I_SENT      = 2'd1,
    OP_I_SENT_WAIT = 2'd2,
    OP_NONE        = 2'd3
  } opcode_e;

  // Decoded kind of a closed frame
  typedef enum logic [2:0] {
    KIND_OTHER = 3'd0,
    KIND_ROL   = 3'd1,
    KIND_NSA   = 3'd2,
    KIND_RR    = 3'd3,
    KIND_I     = 3'd4,
    KIND_BAD   = 3'd5
  } frame_kind_e;

  // Link characters and control codes
  localparam logic [7:0]  FLAG_CHAR     = 8'h7E;
  localparam logic [7:0]  EOP_CHAR      = 8'h5A;
  localparam logic [7:0]  CTL_NSA       = 8'h63;
  localparam logic [7:0]  CTL_ROL       = 8'h0F;
  localparam logic [7:0]  CTL_RR        = 8'h01;
  localparam logic [7:0]  RR_MASK       = 8'h1F;
  localparam logic [7:0]  I_MASK        = 8'h11;
  localparam logic [15:0] CRC_POLY      = 16'h1021;
  localparam logic [15:0] CRC_POLY_REFL = 16'h8408;
  localparam logic [15:0] CRC_INIT      = 16'hFFFF;
  localparam logic [5:0]  COUNT_MAX     = 6'd63;
  localparam logic [5:0]  MIN_FRAME_LEN = 6'd3;
  localparam logic [5:0]  MIN_INFO_LEN  = 6'd4;
  localparam logic [3:0]  SEQ_NONE      = 4'd15;

  // Reset values of the configuration registers
  localparam logic [7:0]  STATION_ADDR_RST = 8'h24;
  localparam logic [7:0]  SYNC_MARKER_RST  = 8'h10;

  // Configuration register indexes
  localparam logic [0:0]  CFG_STATION_ADDR = 1'd0;
  localparam logic [0:0]  CFG_SYNC_MARKER  = 1'd1;

  // Result item carried in the output register
  typedef struct packed {
    logic        frame_end;
    logic        crc_ok;
    frame_kind_e frame_kind;
    logic        send_snrm;
    logic        send_rr;
    logic        seq_mismatch;
    logic        rollcall_done;
    logic        synced;
    logic        acked;
    logic [2:0]  send_count;
    logic [2:0]  recv_count;
    logic [7:0]  control_out;
  } result_t;

  // One byte through the reflected X.25 CRC, LSB first
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      c = c[0] ? ((c >> 1) ^ CRC_POLY_REFL) : (c >> 1);
    end
    return c;
  endfunction

endpackage

// File: rtl/sdlc_frame_receiver_link_top.sv
// ----------------------------------------------------------------------------
// sdlc_frame_receiver_link_top
// SDLC receive path: frame delimiting, X.25 FCS check, control decode and
// link sequence state, one result per input item.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis_*): one request per received 9-bit character
//   (opcode 0) or per transmit event (opcode 1 I frame sent, 2 I frame sent
//   and awaiting acknowledge). Output stream (m_axis_*): exactly one result
//   per input request, in order; tlast marks the character that closed a
//   frame, tuser carries the frame kind.
//   Configuration: cfg_we_i writes cfg_data_i into register cfg_idx_i
//   (0 station address, 1 sync marker); write only while no request is in
//   flight.
// Pipeline:
//   A request is held in the input register, then processed into the output
//   register and offered from there. One request per cycle is sustained
//   while the output is taken; the combinational path between the two
//   registers is the byte-wide CRC update and the close-of-frame decode.
// Reset: clears frame and link state (ack set, nothing sent), both stages
//   empty, configuration to station address 0x24 and sync marker 0x10.
// Stall: while the output is not taken, one more request is taken into the
//   input register, then s_axis_tready drops until the output drains.
// ----------------------------------------------------------------------------
module sdlc_frame_receiver_link_top (
  input  logic        clk_i,
  input  logic        rst_ni,
  // configuration write port
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [7:0]  cfg_data_i,
  // input stream
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] rx_byte
  input  logic [2:0]  s_axis_tuser,   // [1:0] opcode, [2] rx_mark
  // output stream
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // [0] crc_ok, [1] send_snrm, [2] send_rr,
                                      // [3] seq_mismatch, [4] rollcall_done,
                                      // [5] synced, [6] acked, [9:7] send_count,
                                      // [12:10] recv_count, [20:13] control_out,
                                      // [23:21] zero
  output logic        m_axis_tlast,   // frame_end
  output logic [2:0]  m_axis_tuser    // [2:0] frame_kind
);
  import sfr_pkg::*;

  // configuration registers
  logic [7:0] station_addr_q, sync_marker_q;

  // input stage
  logic       in_valid_q;
  logic [1:0] in_op_q;
  logic [7:0] in_byte_q;
  logic       in_mark_q;

  // output stage
  logic       out_valid_q;
  result_t    res_q, res_d;

  // frame and link state
  logic        in_frame_q, in_frame_d;
  logic [5:0]  byte_count_q, byte_count_d;
  logic [7:0]  held0_q, held0_d, held1_q, held1_d;
  logic [15:0] crc_q, crc_d;
  logic [7:0]  control_q, control_d;
  logic [7:0]  first_info_q, first_info_d;
  logic        rollcall_q, rollcall_d;
  logic        sync_q, sync_d;
  logic        ack_q, ack_d;
  logic [2:0]  send_seq_q, send_seq_d;
  logic [2:0]  recv_seq_q, recv_seq_d;
  logic [3:0]  last_sent_q, last_sent_d;

  logic        advance;
  logic        s_accept;
  logic [15:0] fcs;
  logic [2:0]  nr;

  // move the input stage forward when the output register is free or taken
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || advance;
  assign s_accept      = s_axis_tvalid && s_axis_tready;

  assign fcs = ~crc_q;
  assign nr  = control_q[7:5];

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      station_addr_q <= STATION_ADDR_RST;
      sync_marker_q  <= SYNC_MARKER_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_STATION_ADDR: station_addr_q <= cfg_data_i;
        CFG_SYNC_MARKER:  sync_marker_q  <= cfg_data_i;
        default:          ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_accept) begin
      in_op_q   <= s_axis_tuser[1:0];
      in_mark_q <= s_axis_tuser[2];
      in_byte_q <= s_axis_tdata;
    end
  end

  // process one request: next link state and its result
  always_comb begin
    in_frame_d   = in_frame_q;
    byte_count_d = byte_count_q;
    held0_d      = held0_q;
    held1_d      = held1_q;
    crc_d        = crc_q;
    control_d    = control_q;
    first_info_d = first_info_q;
    rollcall_d   = rollcall_q;
    sync_d       = sync_q;
    ack_d        = ack_q;
    send_seq_d   = send_seq_q;
    recv_seq_d   = recv_seq_q;
    last_sent_d  = last_sent_q;
    res_d        = '0;
    res_d.frame_kind = KIND_OTHER;

    case (opcode_e'(in_op_q))
      OP_I_SENT, OP_I_SENT_WAIT: begin
        res_d.control_out = {recv_seq_q, 1'b0, send_seq_q, 1'b0};
        send_seq_d = send_seq_q + 3'd1;
        if (opcode_e'(in_op_q) == OP_I_SENT_WAIT) begin
          last_sent_d = {1'b0, send_seq_d};
          ack_d       = 1'b0;
        end
      end
      OP_RX_CHAR: begin
        if (!in_frame_q) begin
          // open on the marked station address
          if (in_mark_q && in_byte_q == station_addr_q) begin
            in_frame_d   = 1'b1;
            byte_count_d = '0;
            held0_d      = '0;
            held1_d      = '0;
            crc_d        = crc_feed(CRC_INIT, in_byte_q);
          end
        end else if (in_mark_q && in_byte_q == FLAG_CHAR) begin
          // close: check length and FCS, then decode the control byte
          in_frame_d      = 1'b0;
          res_d.frame_end = 1'b1;
          if (byte_count_q < MIN_FRAME_LEN || byte_count_q == COUNT_MAX ||
              held0_q != fcs[7:0] || held1_q != fcs[15:8]) begin
            res_d.frame_kind = KIND_BAD;
          end else begin
            res_d.crc_ok = 1'b1;
            if (control_q == CTL_ROL) begin
              res_d.frame_kind = KIND_ROL;
              res_d.send_snrm  = 1'b1;
            end
            if (control_q == CTL_NSA) begin
              res_d.frame_kind = KIND_NSA;
              rollcall_d = 1'b1;
              send_seq_d = '0;
              recv_seq_d = '0;
            end
            if ((control_q & RR_MASK) == CTL_RR) begin
              res_d.frame_kind = KIND_RR;
              if (send_seq_q != nr) begin
                res_d.seq_mismatch = 1'b1;
              end
              send_seq_d = nr;
              if (last_sent_q == {1'b0, nr}) begin
                ack_d = 1'b1;
              end
            end else if ((control_q & I_MASK) == 8'h00) begin
              res_d.frame_kind   = KIND_I;
              res_d.seq_mismatch = (send_seq_q != nr);
              recv_seq_d         = nr;
              res_d.send_rr      = 1'b1;
              res_d.control_out  = {send_seq_q, 5'b0} | CTL_RR;
              if (byte_count_q >= MIN_INFO_LEN && first_info_q == sync_marker_q) begin
                sync_d = 1'b1;
              end
            end
          end
        end else begin
          // frame byte: capture fields, hold back the last two bytes
          if (byte_count_q == 6'd0) begin
            control_d = in_byte_q;
          end else if (byte_count_q == 6'd1) begin
            first_info_d = in_byte_q;
          end
          if (byte_count_q >= 6'd2) begin
            crc_d = crc_feed(crc_q, held0_q);
          end
          held0_d = held1_q;
          held1_d = in_byte_q;
          if (byte_count_q != COUNT_MAX) begin
            byte_count_d = byte_count_q + 6'd1;
          end
        end
      end
      default: ;
    endcase

    res_d.rollcall_done = rollcall_d;
    res_d.synced        = sync_d;
    res_d.acked         = ack_d;
    res_d.send_count    = send_seq_d;
    res_d.recv_count    = recv_seq_d;
  end

  // link state registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_frame_q   <= 1'b0;
      byte_count_q <= '0;
      held0_q      <= '0;
      held1_q      <= '0;
      crc_q        <= CRC_INIT;
      control_q    <= '0;
      first_info_q <= '0;
      rollcall_q   <= 1'b0;
      sync_q       <= 1'b0;
      ack_q        <= 1'b1;
      send_seq_q   <= '0;
      recv_seq_q   <= '0;
      last_sent_q  <= SEQ_NONE;
    end else if (advance) begin
      in_frame_q   <= in_frame_d;
      byte_count_q <= byte_count_d;
      held0_q      <= held0_d;
      held1_q      <= held1_d;
      crc_q        <= crc_d;
      control_q    <= control_d;
      first_info_q <= first_info_d;
      rollcall_q   <= rollcall_d;
      sync_q       <= sync_d;
      ack_q        <= ack_d;
      send_seq_q   <= send_seq_d;
      recv_seq_q   <= recv_seq_d;
      last_sent_q  <= last_sent_d;
    end
  end

  // output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      res_q <= res_d;
    end
  end

  // drive the output stream
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tlast  = res_q.frame_end;
  assign m_axis_tuser  = res_q.frame_kind;
  assign m_axis_tdata  = {3'b000, res_q.control_out, res_q.recv_count, res_q.send_count,
                          res_q.acked, res_q.synced, res_q.rollcall_done,
                          res_q.seq_mismatch, res_q.send_rr, res_q.send_snrm,
                          res_q.crc_ok};

`ifndef SYNTHESIS
  // a close always leaves the frame
  a_close_leaves_frame: assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && res_d.frame_end |=> !in_frame_q)
    else $error("frame still open after close");

  // a good check is only reported on a closing character
  a_ok_needs_end: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.crc_ok |-> res_q.frame_end)
    else $error("crc_ok without frame_end");

  // an RR request comes only from an I frame
  a_rr_from_i: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && res_q.send_rr |-> res_q.frame_kind == KIND_I)
    else $error("send_rr on a frame that is not an I frame");

  // a full, stalled input stage takes nothing more
  a_no_overrun: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_q && out_valid_q && !m_axis_tready |-> !s_axis_tready)
    else $error("input accepted while both stages are held");

  // a frame opens only on a marked received character
  a_open_on_mark: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_frame_q && in_frame_d && advance |-> in_mark_q && in_op_q == OP_RX_CHAR)
    else $error("frame opened without a marked character");
`endif

endmodule
